// ===== src/cgtd_pkg.sv =====
// ----------------------------------------------------------------------------
// cgtd_pkg
// shared types, constants and action codes of the credit-gated dispatcher
// ----------------------------------------------------------------------------
package cgtd_pkg;

    localparam int NUM_CLASSES_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TAG_W    = 16;
    localparam int ENTRY_W  = 17;
    localparam int SLOT_W   = 8;
    localparam int BUF_W    = 5;
    localparam int CLASS_W  = 2;
    localparam int STATUS_W = 3;
    localparam int ACTION_W = 3;
    localparam int REJ_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [SLOT_W-1:0] MAX_IN_FLIGHT_RST = 8'd16;
    localparam logic [BUF_W-1:0]  MAX_BUFFERED_RST  = 5'd16;
    localparam logic [SLOT_W-1:0] WRITE_COST = 8'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_IN_FLIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BUFFERED  = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_DISPATCH   = 3'd0,
        ACT_QUEUED     = 3'd1,
        ACT_REJ_STORE  = 3'd2,
        ACT_NO_BUDGET  = 3'd3,
        ACT_DROPPED    = 3'd4,
        ACT_DISCARDED  = 3'd5,
        ACT_QUEUE_FULL = 3'd6
    } t_action;

    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd3;

    localparam logic [REJ_W-1:0] REJ_NO_SPACE = 2'd0;
    localparam logic [REJ_W-1:0] REJ_DISABLED = 2'd1;
    localparam logic [REJ_W-1:0] REJ_FAILED   = 2'd2;

    localparam logic REQ_SUBMIT = 1'b0;
    localparam logic REQ_REPLY  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [CLASS_W-1:0]  task_class;
        logic [TAG_W-1:0]    task_tag;
        logic                is_write;
        logic                droppable;
        logic [STATUS_W-1:0] store_status;
        logic                write_exempt;
        logic                budget_ok;
        logic                shutting_down;
    } t_req;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TAG_W-1:0]    out_tag;
        logic [CLASS_W-1:0]  out_class;
        logic                with_batch;
        logic [REJ_W-1:0]    reject_status;
        logic                last;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    // queue command from sequencer to the queue store
    typedef struct packed {
        logic push;
        logic pop;
        logic keep;
    } t_qcmd;

endpackage

// ===== src/cgtd_if.sv =====
// ----------------------------------------------------------------------------
// cgtd_req_if / cgtd_res_if / cgtd_cfg_if
// valid/ready channels of the dispatcher
// ----------------------------------------------------------------------------
interface cgtd_req_if;
    logic            valid;
    logic            ready;
    cgtd_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cgtd_res_if;
    logic            valid;
    logic            ready;
    cgtd_pkg::t_res  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cgtd_cfg_if;
    logic            valid;
    logic            ready;
    cgtd_pkg::t_cfg  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/cgtd_queues.sv =====
// ----------------------------------------------------------------------------
// cgtd_queues
// per-class droppable and non-droppable fifos with head/count pointers
// ----------------------------------------------------------------------------
module cgtd_queues #(
    parameter int NUM_CLASSES = cgtd_pkg::NUM_CLASSES_DEF,
    parameter int QUEUE_DEPTH = cgtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(NUM_CLASSES+1)-1:0]    i_cls,
    input  cgtd_pkg::t_qcmd                     i_cmd,
    input  logic [cgtd_pkg::ENTRY_W-1:0]        i_entry,
    output logic [cgtd_pkg::ENTRY_W-1:0]        o_keep_head,
    output logic [cgtd_pkg::ENTRY_W-1:0]        o_drop_head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    o_keep_cnt,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    o_drop_cnt
);
    localparam int CI_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PT_W = $clog2(QUEUE_DEPTH);
    localparam int CN_W = $clog2(QUEUE_DEPTH+1);
    localparam int MEM_D = NUM_CLASSES * QUEUE_DEPTH;
    localparam int AD_W = $clog2(MEM_D);

    logic [cgtd_pkg::ENTRY_W-1:0] r_keep_mem [MEM_D];
    logic [cgtd_pkg::ENTRY_W-1:0] r_drop_mem [MEM_D];
    logic [PT_W-1:0] r_keep_head [NUM_CLASSES];
    logic [PT_W-1:0] r_drop_head [NUM_CLASSES];
    logic [CN_W-1:0] r_keep_cnt  [NUM_CLASSES];
    logic [CN_W-1:0] r_drop_cnt  [NUM_CLASSES];
    logic [cgtd_pkg::ENTRY_W-1:0] r_keep_rd, r_drop_rd;

    logic [CI_W-1:0] w_ci;
    logic [PT_W-1:0] w_khead, w_dhead, w_kn, w_dn, w_wslot, w_kslot, w_dslot;
    logic [AD_W-1:0] w_kaddr, w_daddr, w_waddr;

    function automatic logic [PT_W-1:0] wrap(input logic [PT_W:0] v);
        logic [PT_W:0] r;
        r = (v >= (PT_W+1)'(QUEUE_DEPTH)) ? v - (PT_W+1)'(QUEUE_DEPTH) : v;
        return r[PT_W-1:0];
    endfunction

    function automatic logic [AD_W-1:0] addr(input logic [CI_W-1:0] c,
                                             input logic [PT_W-1:0] s);
        logic [AD_W+CI_W:0] a;
        a = (AD_W+CI_W+1)'(c) * (AD_W+CI_W+1)'(QUEUE_DEPTH) + (AD_W+CI_W+1)'(s);
        return a[AD_W-1:0];
    endfunction

    assign w_ci    = i_cls[CI_W-1:0];
    assign w_khead = r_keep_head[w_ci];
    assign w_dhead = r_drop_head[w_ci];
    assign w_kn    = wrap({1'b0, w_khead} + 1'b1);
    assign w_dn    = wrap({1'b0, w_dhead} + 1'b1);
    assign w_kslot = i_cmd.pop && i_cmd.keep ? w_kn : w_khead;
    assign w_dslot = i_cmd.pop && !i_cmd.keep ? w_dn : w_dhead;
    assign w_kaddr = addr(w_ci, w_kslot);
    assign w_daddr = addr(w_ci, w_dslot);
    assign w_wslot = i_cmd.keep
        ? wrap({1'b0, w_khead} + (PT_W+1)'(r_keep_cnt[w_ci]))
        : wrap({1'b0, w_dhead} + (PT_W+1)'(r_drop_cnt[w_ci]));
    assign w_waddr = addr(w_ci, w_wslot);

    // memories: one write, registered read of the (next) head
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && i_cmd.keep) begin
            r_keep_mem[w_waddr] <= i_entry;
        end
        if (i_cmd.push && !i_cmd.keep) begin
            r_drop_mem[w_waddr] <= i_entry;
        end
        r_keep_rd <= r_keep_mem[w_kaddr];
        r_drop_rd <= r_drop_mem[w_daddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_keep_head[c] <= '0;
                r_drop_head[c] <= '0;
                r_keep_cnt[c]  <= '0;
                r_drop_cnt[c]  <= '0;
            end
        end else begin
            if (i_cmd.push && i_cmd.keep) begin
                r_keep_cnt[w_ci] <= r_keep_cnt[w_ci] + 1'b1;
            end
            if (i_cmd.push && !i_cmd.keep) begin
                r_drop_cnt[w_ci] <= r_drop_cnt[w_ci] + 1'b1;
            end
            if (i_cmd.pop && i_cmd.keep) begin
                r_keep_cnt[w_ci]  <= r_keep_cnt[w_ci] - 1'b1;
                r_keep_head[w_ci] <= w_kn;
            end
            if (i_cmd.pop && !i_cmd.keep) begin
                r_drop_cnt[w_ci]  <= r_drop_cnt[w_ci] - 1'b1;
                r_drop_head[w_ci] <= w_dn;
            end
        end
    end

    assign o_keep_head = r_keep_rd;
    assign o_drop_head = r_drop_rd;
    assign o_keep_cnt  = r_keep_cnt[w_ci];
    assign o_drop_cnt  = r_drop_cnt[w_ci];
endmodule

// ===== src/credit_gated_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// credit_gated_task_dispatcher
// per-class credit dispatcher with droppable and non-droppable queues
// ----------------------------------------------------------------------------
// channels: i_req (submission or reply), o_res (one action per transfer,
// last marks the final action of an item), i_cfg (register writes:
// index 0 max_in_flight, index 1 max_buffered).
// one item is handled at a time by a small sequencer around one shared
// credit compare and the queue memories. a submission that dispatches or
// is rejected outright shows its result from S_DECIDE, one that queues
// from S_ENQ. a flush passes each task moved through S_EMIT and a drain
// each task checked through S_DR_WAIT and S_DR_CHK, for the registered
// read of the queue head memory; a drain holds each dispatch back by one
// step so the final one can carry last.
// ready stays low until the last result of the item has been taken.
// a reply of a class outside the range gives no result and ends at once.
// reset clears credits and queue pointers and loads register defaults;
// queue memories are not cleared, only written entries are read.
// when the receiver stalls, the sequencer waits with its result held.
// ----------------------------------------------------------------------------
module credit_gated_task_dispatcher #(
    parameter int NUM_CLASSES = cgtd_pkg::NUM_CLASSES_DEF,
    parameter int QUEUE_DEPTH = cgtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgtd_req_if.sink    i_req,
    cgtd_res_if.source  o_res,
    cgtd_cfg_if.sink    i_cfg
);
    localparam int CN_W = $clog2(QUEUE_DEPTH+1);
    localparam int CI_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CL_W = $clog2(NUM_CLASSES+1);
    localparam int SW   = cgtd_pkg::SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_FLUSH_D, S_FLUSH_K, S_ENQ,
        S_DR_WAIT, S_DR_CHK, S_EMIT
    } t_state;

    t_state r_state, r_ret;
    cgtd_pkg::t_req r_req;
    cgtd_pkg::t_res r_res;
    cgtd_pkg::t_res r_held;
    logic r_held_valid;
    logic r_out_valid;
    logic r_keep_phase;
    logic [SW-1:0] r_slots [NUM_CLASSES];
    logic [SW-1:0] r_max_if;
    logic [cgtd_pkg::BUF_W-1:0] r_max_buf;

    cgtd_pkg::t_qcmd w_cmd;
    logic [cgtd_pkg::ENTRY_W-1:0] w_khead, w_dhead, w_head;
    logic [CN_W-1:0] w_kcnt, w_dcnt;
    logic [CI_W-1:0] w_ci;
    logic w_cls_ok;
    logic [SW:0] w_sum;
    logic [SW-1:0] w_cost;
    logic w_fits;
    logic w_bad_store;

    assign w_ci     = r_req.task_class[CI_W-1:0];
    assign w_cls_ok = 32'(r_req.task_class) < NUM_CLASSES;

    cgtd_queues #(.NUM_CLASSES(NUM_CLASSES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_queues (
        .i_clk, .i_rst_n,
        .i_cls       (CL_W'(r_req.task_class)),
        .i_cmd       (w_cmd),
        .i_entry     ({r_req.is_write, r_req.task_tag}),
        .o_keep_head (w_khead),
        .o_drop_head (w_dhead),
        .o_keep_cnt  (w_kcnt),
        .o_drop_cnt  (w_dcnt)
    );

    // shared credit compare: the pending item or the queue head
    assign w_head = r_keep_phase ? w_khead : w_dhead;
    assign w_cost = ((r_state == S_DECIDE) ? r_req.is_write : w_head[16])
                    ? cgtd_pkg::WRITE_COST : SW'(1);
    assign w_sum  = {1'b0, r_slots[w_ci]} + {1'b0, w_cost};
    assign w_fits = w_sum <= {1'b0, r_max_if};
    assign w_bad_store = r_req.is_write && !r_req.write_exempt
                         && r_req.store_status >= cgtd_pkg::ST_NO_SPACE;

    logic w_can_step;
    assign w_can_step = !r_out_valid || o_res.ready;

    always_comb begin
        w_cmd = '0;
        w_cmd.keep = r_keep_phase;
        if (w_can_step) begin
            unique case (r_state)
                S_FLUSH_D: begin
                    w_cmd.keep = 1'b0;
                    w_cmd.pop  = w_dcnt != '0;
                end
                S_FLUSH_K: begin
                    w_cmd.keep = 1'b1;
                    w_cmd.pop  = w_kcnt != '0;
                end
                S_ENQ: begin
                    w_cmd.keep = !r_req.droppable;
                    w_cmd.push = r_req.droppable
                                 || 32'(w_kcnt) < QUEUE_DEPTH;
                end
                S_DR_CHK: begin
                    w_cmd.pop = (r_keep_phase ? w_kcnt != '0 : w_dcnt != '0)
                                && w_fits;
                end
                default: ;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    function automatic cgtd_pkg::t_res mk(input cgtd_pkg::t_action a,
        input logic [15:0] tag, input logic [1:0] cls,
        input logic b, input logic [1:0] rj, input logic l);
        cgtd_pkg::t_res r;
        r.action = a; r.out_tag = tag; r.out_class = cls;
        r.with_batch = b; r.reject_status = rj; r.last = l;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held_valid <= 1'b0;
            r_keep_phase <= 1'b0;
            r_max_if <= cgtd_pkg::MAX_IN_FLIGHT_RST;
            r_max_buf <= cgtd_pkg::MAX_BUFFERED_RST;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_slots[c] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.data.index == cgtd_pkg::REG_MAX_IN_FLIGHT) begin
                    r_max_if <= i_cfg.data.data;
                end else begin
                    r_max_buf <= i_cfg.data.data[cgtd_pkg::BUF_W-1:0];
                end
            end
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_can_step) begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_req.valid && !r_out_valid) begin
                            r_req <= i_req.data;
                            r_state <= S_DECIDE;
                        end
                    end
                    S_DECIDE: begin
                        if (r_req.req_type == cgtd_pkg::REQ_REPLY) begin
                            if (!w_cls_ok) begin
                                r_state <= S_IDLE;
                            end else begin
                                if (r_slots[w_ci] != '0) begin
                                    r_slots[w_ci] <= r_slots[w_ci] - 1'b1;
                                end
                                r_keep_phase <= 1'b1;
                                r_state <= S_DR_WAIT;
                            end
                        end else if (!w_cls_ok) begin
                            r_res <= mk(cgtd_pkg::ACT_DROPPED, r_req.task_tag,
                                        r_req.task_class, 1'b0, '0, 1'b1);
                            r_out_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (w_bad_store) begin
                            r_res <= mk(cgtd_pkg::ACT_REJ_STORE, r_req.task_tag,
                                r_req.task_class, 1'b0,
                                r_req.store_status == cgtd_pkg::ST_NO_SPACE
                                    ? cgtd_pkg::REJ_NO_SPACE
                                    : r_req.store_status == cgtd_pkg::ST_DISABLED
                                    ? cgtd_pkg::REJ_DISABLED
                                    : cgtd_pkg::REJ_FAILED, 1'b1);
                            r_out_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (r_req.is_write && !r_req.budget_ok) begin
                            r_res <= mk(cgtd_pkg::ACT_NO_BUDGET, r_req.task_tag,
                                        r_req.task_class, 1'b0, '0, 1'b1);
                            r_out_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (w_fits) begin
                            r_slots[w_ci] <= w_sum[SW-1:0];
                            r_res <= mk(cgtd_pkg::ACT_DISPATCH, r_req.task_tag,
                                r_req.task_class, r_req.is_write, '0, 1'b1);
                            r_out_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (32'(r_max_buf) <= 32'(w_dcnt)
                                     || 32'(w_dcnt) >= QUEUE_DEPTH) begin
                            r_state <= S_FLUSH_D;
                        end else begin
                            r_state <= S_ENQ;
                        end
                    end
                    S_FLUSH_D: begin
                        if (w_dcnt != '0) begin
                            r_res <= mk(cgtd_pkg::ACT_DROPPED, w_dhead[15:0],
                                        r_req.task_class, 1'b0, '0, 1'b0);
                            r_out_valid <= 1'b1;
                            r_ret <= S_FLUSH_D;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= r_req.shutting_down ? S_FLUSH_K : S_ENQ;
                        end
                    end
                    S_FLUSH_K: begin
                        if (w_kcnt != '0) begin
                            r_res <= mk(cgtd_pkg::ACT_DISCARDED, w_khead[15:0],
                                        r_req.task_class, 1'b0, '0, 1'b0);
                            r_out_valid <= 1'b1;
                            r_ret <= S_FLUSH_K;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_ENQ;
                        end
                    end
                    S_ENQ: begin
                        r_res <= mk((r_req.droppable
                                     || 32'(w_kcnt) < QUEUE_DEPTH)
                                    ? cgtd_pkg::ACT_QUEUED
                                    : cgtd_pkg::ACT_QUEUE_FULL,
                                    r_req.task_tag, r_req.task_class,
                                    1'b0, '0, 1'b1);
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                    S_EMIT: begin
                        // head read of the popped queue settles
                        r_state <= r_ret;
                    end
                    S_DR_WAIT: begin
                        r_state <= S_DR_CHK;
                    end
                    S_DR_CHK: begin
                        if (w_cmd.pop) begin
                            r_slots[w_ci] <= w_sum[SW-1:0];
                            if (r_held_valid) begin
                                r_res <= r_held;
                                r_out_valid <= 1'b1;
                            end
                            r_held <= mk(cgtd_pkg::ACT_DISPATCH, w_head[15:0],
                                r_req.task_class, w_head[16], '0, 1'b0);
                            r_held_valid <= 1'b1;
                            r_state <= S_DR_WAIT;
                        end else if (r_keep_phase) begin
                            r_keep_phase <= 1'b0;
                            r_state <= S_DR_WAIT;
                        end else begin
                            // close the item: the held dispatch carries last
                            if (r_held_valid) begin
                                r_res <= mk(cgtd_pkg::t_action'(r_held.action),
                                    r_held.out_tag, r_held.out_class,
                                    r_held.with_batch, r_held.reject_status, 1'b1);
                                r_out_valid <= 1'b1;
                                r_held_valid <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

// ===== src/cgtd_checker.sv =====
// ----------------------------------------------------------------------------
// cgtd_checker
// port-level checks of the dispatcher, bound to the top level
// ----------------------------------------------------------------------------
module cgtd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           o_res_valid,
    input logic           o_res_ready,
    input cgtd_pkg::t_res o_res_data
);
    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res_ready |=> o_res_valid && $stable(o_res_data))
        else $error("result changed while stalled");

    // no new item while a result is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !i_req_ready)
        else $error("ready while result pending");

    // item accepted means not ready next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready right after accept");

    // batch only on dispatch
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res_data.with_batch |->
            o_res_data.action == cgtd_pkg::ACT_DISPATCH)
        else $error("batch on non-dispatch");
endmodule

bind credit_gated_task_dispatcher cgtd_checker u_cgtd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_res_valid (o_res.valid),
    .o_res_ready (o_res.ready),
    .o_res_data  (o_res.data)
);
